// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define OTSU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("otsu assertion failed");
// condition must never be seen outside reset
`define OTSU_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("otsu forbidden condition seen");
`else
`define OTSU_ASSERT(lbl, clk, rst_n, prop)
`define OTSU_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: rtl/otsu_pkg.sv
`timescale 1ns / 1ps
package otsu_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_SAMPLES = 4096;
  localparam int NUM_BINS    = 256;
  localparam int THR_W       = 24;

  localparam int ADDR_W   = $clog2(MAX_SAMPLES);
  localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
  localparam int BIN_W    = $clog2(NUM_BINS);
  localparam int Q_W      = BIN_W + 1;
  localparam int SUM_W    = CNT_W + BIN_W;
  localparam int P_W      = SUM_W + CNT_W;
  localparam int SQ_W     = 2 * P_W;
  localparam int DEN_W    = 2 * CNT_W;
  localparam int ML_W     = P_W + DEN_W;
  localparam int CMP_W    = SQ_W + DEN_W;
  localparam int STEP_W   = $clog2(Q_W);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // one classified sample on its way from front to back
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
    logic                          keep;
    logic                          ovf;
  } otsu_item_t;

endpackage

// File: rtl/otsu_front.sv
`timescale 1ns / 1ps
module otsu_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [otsu_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                             in_last,
  input  logic                             q_full,
  output logic                             in_ready,
  output logic                             q_push,
  output otsu_pkg::otsu_item_t             q_item
);
  import otsu_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic             ovf_r;
  logic             keep;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign keep     = cnt_r < CNT_W'(MAX_SAMPLES);

  assign q_item.sample = in_sample;
  assign q_item.last   = in_last;
  assign q_item.keep   = keep;
  assign q_item.ovf    = ovf_r || !keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (q_push) begin
      if (in_last) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        cnt_r <= keep ? cnt_r + 1'b1 : cnt_r;
        ovf_r <= ovf_r || !keep;
      end
    end
  end

endmodule

// File: rtl/otsu_fifo.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module otsu_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  otsu_pkg::otsu_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output otsu_pkg::otsu_item_t pop_item,
  output logic                 valid
);
  import otsu_pkg::*;

  otsu_item_t         slot_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r;
  logic [FIFO_AW-1:0] rp_r;
  logic [FIFO_AW:0]   cnt_r;

  assign full     = cnt_r == (FIFO_AW+1)'(FIFO_DEPTH);
  assign valid    = cnt_r != '0;
  assign pop_item = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  `OTSU_NEVER(a_push_when_full, clk, rst_n, push && full)
  `OTSU_NEVER(a_pop_when_empty, clk, rst_n, pop && !valid)
  `OTSU_ASSERT(a_fill_bounded, clk, rst_n, cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH))

endmodule

// File: rtl/otsu_div.sv
`timescale 1ns / 1ps
module otsu_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [otsu_pkg::SAMPLE_BITS-1:0] num,
  input  logic [otsu_pkg::SAMPLE_BITS-1:0] den,
  output logic                             done,
  output logic [otsu_pkg::Q_W-1:0]         quo
);
  import otsu_pkg::*;

  // restoring divide of (num << BIN_W) by den, one quotient bit a cycle
  logic                   busy_r;
  logic                   done_r;
  logic [STEP_W-1:0]      step_r;
  logic [SAMPLE_BITS-1:0] rem_r;
  logic [SAMPLE_BITS-1:0] den_r;
  logic [Q_W-1:0]         sh_r;
  logic [Q_W-1:0]         q_r;
  logic [SAMPLE_BITS:0]   trial;
  logic                   fits;

  assign trial = {rem_r, sh_r[Q_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign done  = done_r;
  assign quo   = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && !start && (step_r == STEP_W'(Q_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(Q_W - 1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num >> 1;
      sh_r  <= {num[0], {BIN_W{1'b0}}};
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? SAMPLE_BITS'(trial - {1'b0, den_r}) : trial[SAMPLE_BITS-1:0];
      sh_r  <= sh_r << 1;
      q_r   <= {q_r[Q_W-2:0], fits};
    end
  end

endmodule

// File: rtl/otsu_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module otsu_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             item_valid,
  input  otsu_pkg::otsu_item_t             item,
  output logic                             item_pop,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic [otsu_pkg::THR_W-1:0]       res_thr,
  output logic [otsu_pkg::BIN_W-1:0]       res_bin,
  output logic                             res_flat,
  output logic                             res_ovf
);
  import otsu_pkg::*;

  typedef enum logic [19:0] {
    ST_LOAD = 20'h00001,
    ST_CHK  = 20'h00002,
    ST_CLR  = 20'h00004,
    ST_BRD  = 20'h00008,
    ST_BST  = 20'h00010,
    ST_BDIV = 20'h00020,
    ST_BHRD = 20'h00040,
    ST_BHWR = 20'h00080,
    ST_SRD  = 20'h00100,
    ST_SACC = 20'h00200,
    ST_SMUL = 20'h00400,
    ST_SD   = 20'h00800,
    ST_SSQ  = 20'h01000,
    ST_SM0  = 20'h02000,
    ST_SM1  = 20'h04000,
    ST_SM2  = 20'h08000,
    ST_SM3  = 20'h10000,
    ST_SADD = 20'h20000,
    ST_SCMP = 20'h40000,
    ST_FIN  = 20'h80000
  } otsu_state_t;

  otsu_state_t state_r, state_nxt;

  logic signed [SAMPLE_BITS-1:0] store_mem [MAX_SAMPLES];
  logic [CNT_W-1:0]              hist_mem  [NUM_BINS];
  logic signed [SAMPLE_BITS-1:0] store_q;
  logic [CNT_W-1:0]              hist_q;

  logic signed [SAMPLE_BITS-1:0] min_r, max_r;
  logic [SAMPLE_BITS-1:0]        range_r;
  logic [CNT_W-1:0]              wcnt_r, k_r;
  logic                          ovf_r;
  logic [BIN_W-1:0]              clr_r, bin_r, i_r, best_r;
  logic [SUM_W-1:0]              sum_all_r, sumb_r;
  logic [CNT_W-1:0]              wb_r, wf_r;
  logic                          have_r;
  logic [P_W-1:0]                p1_r, p2_r, absd_r;
  logic [DEN_W-1:0]              den_r, best_den_r;
  logic [SQ_W-1:0]               sq_r, best_sq_r;
  logic [ML_W-1:0]               l_lo_r, l_hi_r, r_lo_r, r_hi_r;
  logic [CMP_W-1:0]              lhs_r, rhs_r;
  logic                          out_valid_r;
  logic [THR_W-1:0]              out_thr_r;
  logic [BIN_W-1:0]              out_bin_r;
  logic                          out_flat_r, out_ovf_r;

  logic             hist_we;
  logic [BIN_W-1:0] hist_waddr, hist_raddr;
  logic [CNT_W-1:0] hist_wdata;
  logic             store_we;
  logic [CNT_W-1:0] wb_n;
  logic [P_W-1:0]   mul_a;
  logic [DEN_W-1:0] mul_b;
  logic [ML_W-1:0]  mul_p;
  logic             div_start, div_done;
  logic [Q_W-1:0]   div_q;
  logic [BIN_W-1:0] div_bin;
  logic             is_flat;
  logic [THR_W-1:0] thr_val;

  otsu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (SAMPLE_BITS'(store_q - min_r)),
    .den   (range_r),
    .done  (div_done),
    .quo   (div_q)
  );

  assign div_start = state_r == ST_BST;
  assign div_bin   = div_q[Q_W-1] ? BIN_W'(NUM_BINS - 1) : div_q[BIN_W-1:0];
  assign item_pop  = (state_r == ST_LOAD) && item_valid;
  assign store_we  = item_pop && item.keep;
  assign wb_n      = wb_r + hist_q;
  assign is_flat   = !(max_r > min_r);
  assign thr_val   = THR_W'({min_r, 8'b0})
                   + (is_flat ? '0 : THR_W'(range_r) * THR_W'(Q_W'(best_r) + 1'b1));

  assign hist_we    = (state_r == ST_CLR) || (state_r == ST_BHWR);
  assign hist_waddr = (state_r == ST_CLR) ? clr_r : bin_r;
  assign hist_wdata = (state_r == ST_CLR) ? '0 : hist_q + 1'b1;
  assign hist_raddr = (state_r == ST_BHRD) ? bin_r : i_r;

  // one shared multiplier for the four partial products of the cross compare
  always_comb begin
    unique case (state_r)
      ST_SM0: begin
        mul_a = sq_r[P_W-1:0];
        mul_b = best_den_r;
      end
      ST_SM1: begin
        mul_a = sq_r[SQ_W-1:P_W];
        mul_b = best_den_r;
      end
      ST_SM2: begin
        mul_a = best_sq_r[P_W-1:0];
        mul_b = den_r;
      end
      default: begin
        mul_a = best_sq_r[SQ_W-1:P_W];
        mul_b = den_r;
      end
    endcase
  end
  assign mul_p = ML_W'(mul_a) * ML_W'(mul_b);

  always_ff @(posedge clk) begin
    if (store_we) store_mem[wcnt_r[ADDR_W-1:0]] <= item.sample;
    store_q <= store_mem[k_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_q <= hist_mem[hist_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (item_pop && item.last) state_nxt = ST_CHK;
      ST_CHK:  state_nxt = is_flat ? ST_FIN : ST_CLR;
      ST_CLR:  if (clr_r == BIN_W'(NUM_BINS - 1)) state_nxt = ST_BRD;
      ST_BRD:  state_nxt = ST_BST;
      ST_BST:  state_nxt = ST_BDIV;
      ST_BDIV: if (div_done) state_nxt = ST_BHRD;
      ST_BHRD: state_nxt = ST_BHWR;
      ST_BHWR: state_nxt = (k_r + 1'b1 == wcnt_r) ? ST_SRD : ST_BRD;
      ST_SRD:  state_nxt = ST_SACC;
      ST_SACC: begin
        if (wb_n == '0) state_nxt = (i_r == BIN_W'(NUM_BINS - 1)) ? ST_FIN : ST_SRD;
        else if (wb_n == wcnt_r) state_nxt = ST_FIN;
        else state_nxt = ST_SMUL;
      end
      ST_SMUL: state_nxt = ST_SD;
      ST_SD:   state_nxt = ST_SSQ;
      ST_SSQ:  state_nxt = ST_SM0;
      ST_SM0: begin
        if (have_r) state_nxt = ST_SM1;
        else state_nxt = (i_r == BIN_W'(NUM_BINS - 1)) ? ST_FIN : ST_SRD;
      end
      ST_SM1:  state_nxt = ST_SM2;
      ST_SM2:  state_nxt = ST_SM3;
      ST_SM3:  state_nxt = ST_SADD;
      ST_SADD: state_nxt = ST_SCMP;
      ST_SCMP: state_nxt = (i_r == BIN_W'(NUM_BINS - 1)) ? ST_FIN : ST_SRD;
      ST_FIN:  if (!out_valid_r) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      min_r       <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      max_r       <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      wcnt_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
      best_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && res_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_LOAD: begin
          if (store_we) begin
            wcnt_r <= wcnt_r + 1'b1;
            if (item.sample < min_r) min_r <= item.sample;
            if (item.sample > max_r) max_r <= item.sample;
          end
          if (item_pop && item.last) ovf_r <= item.ovf;
        end
        ST_CHK: begin
          best_r <= '0;
          have_r <= 1'b0;
        end
        ST_SM0: begin
          if (!have_r) begin
            have_r <= 1'b1;
            best_r <= i_r;
          end
        end
        ST_SCMP: if (lhs_r > rhs_r) best_r <= i_r;
        ST_FIN: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            min_r       <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            max_r       <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            wcnt_r      <= '0;
            ovf_r       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_CHK: begin
        range_r <= SAMPLE_BITS'(max_r - min_r);
        clr_r   <= '0;
      end
      ST_CLR: begin
        clr_r     <= clr_r + 1'b1;
        k_r       <= '0;
        sum_all_r <= '0;
      end
      ST_BDIV: if (div_done) bin_r <= div_bin;
      ST_BHWR: begin
        k_r       <= k_r + 1'b1;
        sum_all_r <= sum_all_r + SUM_W'(bin_r);
        i_r       <= '0;
        wb_r      <= '0;
        sumb_r    <= '0;
      end
      ST_SACC: begin
        if (wb_n == '0) begin
          i_r <= i_r + 1'b1;
        end else begin
          wb_r   <= wb_n;
          wf_r   <= wcnt_r - wb_n;
          sumb_r <= sumb_r + SUM_W'(i_r) * SUM_W'(hist_q);
        end
      end
      ST_SMUL: begin
        p1_r  <= P_W'(sumb_r) * P_W'(wcnt_r);
        p2_r  <= P_W'(sum_all_r) * P_W'(wb_r);
        den_r <= DEN_W'(wb_r) * DEN_W'(wf_r);
      end
      ST_SD:  absd_r <= (p1_r >= p2_r) ? p1_r - p2_r : p2_r - p1_r;
      ST_SSQ: sq_r   <= SQ_W'(absd_r) * SQ_W'(absd_r);
      ST_SM0: begin
        if (!have_r) begin
          best_sq_r  <= sq_r;
          best_den_r <= den_r;
          i_r        <= i_r + 1'b1;
        end else begin
          l_lo_r <= mul_p;
        end
      end
      ST_SM1: l_hi_r <= mul_p;
      ST_SM2: r_lo_r <= mul_p;
      ST_SM3: r_hi_r <= mul_p;
      ST_SADD: begin
        lhs_r <= (CMP_W'(l_hi_r) << P_W) + CMP_W'(l_lo_r);
        rhs_r <= (CMP_W'(r_hi_r) << P_W) + CMP_W'(r_lo_r);
      end
      ST_SCMP: begin
        if (lhs_r > rhs_r) begin
          best_sq_r  <= sq_r;
          best_den_r <= den_r;
        end
        i_r <= i_r + 1'b1;
      end
      ST_FIN: begin
        if (!out_valid_r) begin
          out_thr_r  <= thr_val;
          out_bin_r  <= is_flat ? '0 : best_r;
          out_flat_r <= is_flat;
          out_ovf_r  <= ovf_r;
        end
      end
      default: ;
    endcase
  end

  assign res_valid = out_valid_r;
  assign res_thr   = out_thr_r;
  assign res_bin   = out_bin_r;
  assign res_flat  = out_flat_r;
  assign res_ovf   = out_ovf_r;

  `OTSU_ASSERT(a_div_done_in_wait, clk, rst_n, div_done |-> state_r == ST_BDIV)
  `OTSU_ASSERT(a_pop_only_loading, clk, rst_n, item_pop |-> state_r == ST_LOAD)
  `OTSU_ASSERT(a_store_bounded, clk, rst_n, wcnt_r <= CNT_W'(MAX_SAMPLES))
  `OTSU_ASSERT(a_result_after_fin, clk, rst_n,
               $rose(out_valid_r) |-> $past(state_r) == ST_FIN)

endmodule

// File: rtl/otsu_threshold_unit.sv
`timescale 1ns / 1ps
// channel  dir  tdata (low bit up)                     tlast       tuser
// in_      in   sample[15:0]                           last        -
// out_     out  threshold_q8[23:0], best_bin[31:24]    -           flat[0], overflowed[1]
//
// samples are taken one per cycle into a four-entry queue and written to the
// sample store at one per cycle while the back end is loading; after the last
// sample the back end runs the flat check and, unless the frame is flat, clears
// the histogram, bins each stored sample (serial divider, one quotient bit a
// cycle, plus histogram read-modify-write) and scans the histogram bins, with
// the cross compare sharing one multiplier. reset is synchronous and active low
// and empties the queue; the input stalls when the queue is full, and a finished
// result waits in the output register, holding the back end only when the next
// frame finishes before it is taken.
module otsu_threshold_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sample[15:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // threshold_q8[23:0], best_bin[31:24]
  output logic [1:0]  out_tuser   // flat[0], overflowed[1]
);
  import otsu_pkg::*;

  logic             q_full, q_push, q_valid, q_pop;
  otsu_item_t       q_in_item, q_out_item;
  logic [THR_W-1:0] thr;
  logic [BIN_W-1:0] bin;
  logic             flat, ovf;

  // front: classify each transfer as stored or dropped
  otsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_sample (in_tdata),
    .in_last   (in_tlast),
    .q_full    (q_full),
    .in_ready  (in_tready),
    .q_push    (q_push),
    .q_item    (q_in_item)
  );

  // short queue decoupling intake from the compute phase
  otsu_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out_item),
    .valid     (q_valid)
  );

  // back: store, bin, scan and produce the result
  otsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item       (q_out_item),
    .item_pop   (q_pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_thr    (thr),
    .res_bin    (bin),
    .res_flat   (flat),
    .res_ovf    (ovf)
  );

  assign out_tdata = {bin, thr};
  assign out_tuser = {ovf, flat};

endmodule
